// File: rtl/mbd_pkg.sv
package mbd_pkg;

    // default line length limit and configuration register geometry
    localparam int DEFAULT_MAX_WIDTH = 2048;
    localparam int CFG_W             = 12;
    localparam int ADDR_W            = 3;
    localparam int DATA_W            = 32;

    localparam logic [CFG_W-1:0] DIM_RESET    = 12'd2048;
    localparam logic [CFG_W-1:0] DIM_MIN      = 12'd2;
    localparam logic [CFG_W-1:0] HEIGHT_LIMIT = 12'd2048;

    // register index, taken from paddr[2]
    localparam logic REG_SOURCE_WIDTH  = 1'b0;
    localparam logic REG_SOURCE_HEIGHT = 1'b1;

    // horizontal pair sums of one column pair, 9 bits per channel
    typedef struct packed {
        logic [8:0] alpha;
        logic [8:0] blue;
        logic [8:0] green;
        logic [8:0] red;
    } t_pair;

endpackage

// File: rtl/mbd_line_ram.sv
module mbd_line_ram
    import mbd_pkg::*;
#(
    parameter int DEPTH = DEFAULT_MAX_WIDTH / 2,
    parameter int AW    = $clog2(DEFAULT_MAX_WIDTH / 2)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic          i_re,
    input  logic [AW-1:0] i_addr,
    input  t_pair         i_wdata,
    output t_pair         o_rdata
);

    t_pair r_mem [DEPTH];
    t_pair r_rdata;

    // single port, registered read data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/mipmap_box_downsample.sv
// path: the request carrying a block's bottom-right texel loads stage 1 and the line
//   store read; the block result then enters the output register when it can drain
// throughput: one source texel per cycle unless o_in_stall holds it, set by the single line store port
//   (one write per even-row pair, one read per odd-row pair)
// reset: synchronous active low; indices and valids clear, sizes reset to 2048
module mipmap_box_downsample
    import mbd_pkg::*;
#(
    parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    // source texel channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [7:0]        i_in_red,
    input  logic [7:0]        i_in_green,
    input  logic [7:0]        i_in_blue,
    input  logic [7:0]        i_in_alpha,
    // reduced texel channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [7:0]        o_out_red,
    output logic [7:0]        o_out_green,
    output logic [7:0]        o_out_blue,
    output logic [7:0]        o_out_alpha,
    output logic              o_end_of_level
);

    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int AW = $clog2(LINE_DEPTH);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int EW = (WW > CFG_W) ? WW : CFG_W;
    localparam logic [EW-1:0] MAX_W_E = EW'(MAX_WIDTH);
    localparam logic [EW-1:0] MIN_W_E = EW'(DIM_MIN);

    logic [CFG_W-1:0] r_source_width;
    logic [CFG_W-1:0] r_source_height;
    logic [CW-1:0]    r_col;
    logic [10:0]      r_row;
    logic [31:0]      r_held;
    logic             r_s1_valid;
    t_pair            r_s1_pair;
    logic             r_s1_eol;
    logic             r_out_valid;
    logic [7:0]       r_out_red;
    logic [7:0]       r_out_green;
    logic [7:0]       r_out_blue;
    logic [7:0]       r_out_alpha;
    logic             r_out_eol;

    logic [EW-1:0]    w_ext;
    logic [EW-1:0]    w_sat;
    logic [WW-1:0]    eff_w;
    logic [WW-1:0]    col_ext;
    logic [WW-1:0]    col_next;
    logic [WW-1:0]    last_col;
    logic [CFG_W-1:0] eff_h;
    logic [CFG_W-1:0] row_ext;
    logic [CFG_W-1:0] row_next;
    logic [CFG_W-1:0] last_row;
    logic             cfg_write;
    logic             accept;
    logic             s1_adv;
    logic             ram_we;
    logic             ram_re;
    logic [AW-1:0]    ram_addr;
    t_pair            pair;
    t_pair            above;
    logic [9:0]       sum_red;
    logic [9:0]       sum_green;
    logic [9:0]       sum_blue;
    logic [9:0]       sum_alpha;

    // configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_SOURCE_HEIGHT)
                     ? {{(DATA_W-CFG_W){1'b0}}, r_source_height}
                     : {{(DATA_W-CFG_W){1'b0}}, r_source_width};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_width  <= DIM_RESET;
            r_source_height <= DIM_RESET;
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_SOURCE_WIDTH:  r_source_width  <= pwdata[CFG_W-1:0];
                REG_SOURCE_HEIGHT: r_source_height <= pwdata[CFG_W-1:0];
                default:           r_source_width  <= r_source_width;
            endcase
        end
    end

    // effective sizes, saturated to the supported range
    always_comb begin
        w_ext = EW'(r_source_width);
        priority if (w_ext < MIN_W_E) begin
            w_sat = MIN_W_E;
        end else if (w_ext > MAX_W_E) begin
            w_sat = MAX_W_E;
        end else begin
            w_sat = w_ext;
        end
        priority if (r_source_height < DIM_MIN) begin
            eff_h = DIM_MIN;
        end else if (r_source_height > HEIGHT_LIMIT) begin
            eff_h = HEIGHT_LIMIT;
        end else begin
            eff_h = r_source_height;
        end
    end

    assign eff_w    = w_sat[WW-1:0];
    assign col_ext  = WW'(r_col);
    assign col_next = col_ext + WW'(1);
    assign last_col = {eff_w[WW-1:1], 1'b0} - WW'(1);
    assign row_ext  = {1'b0, r_row};
    assign row_next = row_ext + 12'd1;
    assign last_row = {eff_h[CFG_W-1:1], 1'b0} - 12'd1;

    // handshake: stage 1 only blocks when the output register cannot drain
    assign s1_adv     = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign accept     = i_in_valid && !o_in_stall;

    // raster position, restarted by any register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (cfg_write) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (col_next >= eff_w) begin
                r_col <= '0;
                r_row <= (row_next >= eff_h) ? 11'd0 : row_next[10:0];
            end else begin
                r_col <= col_next[CW-1:0];
            end
        end
    end

    // even-column texel waits for its right neighbor
    always_ff @(posedge i_clk) begin
        if (accept && !r_col[0]) begin
            r_held <= {i_in_alpha, i_in_blue, i_in_green, i_in_red};
        end
    end

    // horizontal pair sums
    assign pair.red   = {1'b0, r_held[7:0]}   + {1'b0, i_in_red};
    assign pair.green = {1'b0, r_held[15:8]}  + {1'b0, i_in_green};
    assign pair.blue  = {1'b0, r_held[23:16]} + {1'b0, i_in_blue};
    assign pair.alpha = {1'b0, r_held[31:24]} + {1'b0, i_in_alpha};

    // even rows store the pair, odd rows fetch the pair above
    assign ram_we   = accept && r_col[0] && !r_row[0];
    assign ram_re   = accept && r_col[0] && r_row[0];
    assign ram_addr = r_col[AW:1];

    mbd_line_ram #(
        .DEPTH (LINE_DEPTH),
        .AW    (AW)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (pair),
        .o_rdata (above)
    );

    // stage 1: lower pair waits here for the line store read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (ram_re) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ram_re) begin
            r_s1_pair <= pair;
            r_s1_eol  <= (col_ext == last_col) && (row_ext == last_row);
        end
    end

    // vertical sum of the two pairs, floor of the quarter
    assign sum_red   = {1'b0, above.red}   + {1'b0, r_s1_pair.red};
    assign sum_green = {1'b0, above.green} + {1'b0, r_s1_pair.green};
    assign sum_blue  = {1'b0, above.blue}  + {1'b0, r_s1_pair.blue};
    assign sum_alpha = {1'b0, above.alpha} + {1'b0, r_s1_pair.alpha};

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_valid) begin
            r_out_red   <= sum_red[9:2];
            r_out_green <= sum_green[9:2];
            r_out_blue  <= sum_blue[9:2];
            r_out_alpha <= sum_alpha[9:2];
            r_out_eol   <= r_s1_eol;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_red      = r_out_red;
    assign o_out_green    = r_out_green;
    assign o_out_blue     = r_out_blue;
    assign o_out_alpha    = r_out_alpha;
    assign o_end_of_level = r_out_eol;

    // a line store read always lands in stage 1
    a_read_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_re |=> r_s1_valid)
        else $error("line store read without stage 1 entry");

    // blocked stage 1 keeps its pair while the read data is not refetched
    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |=> (r_s1_valid && $stable(r_s1_pair) && !$past(ram_re)))
        else $error("stage 1 lost its pair while blocked");

    // input is never stalled while stage 1 is empty
    a_stall_needs_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_valid)
        else $error("input stalled with empty stage 1");

    // column position stays inside the effective width
    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        col_ext < eff_w)
        else $error("column index beyond effective width");

    // store write and read never in the same cycle
    a_one_port_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("line store write and read together");

endmodule

// File: verif/mip_level_checker.sv
`timescale 1ns / 100ps

module mip_level_checker
    import mbd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration port
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [ADDR_W-1:0] i_paddr,
    input  logic [DATA_W-1:0] i_pwdata,
    input  logic [DATA_W-1:0] i_prdata,
    input  logic              i_pready,
    // source texel channel
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic [7:0]        i_in_red,
    input  logic [7:0]        i_in_green,
    input  logic [7:0]        i_in_blue,
    input  logic [7:0]        i_in_alpha,
    // reduced texel channel
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [7:0]        i_out_red,
    input  logic [7:0]        i_out_green,
    input  logic [7:0]        i_out_blue,
    input  logic [7:0]        i_out_alpha,
    input  logic              i_end_of_level,
    output int                o_fail_count,
    output int                o_pending
);

    localparam int PAIR_SLOTS = DEFAULT_MAX_WIDTH / 2;

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_texel;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       end_of_level;
    } t_block_avg;

    // predicted block state
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    t_texel           held;
    t_pair            pair_sums [PAIR_SLOTS];
    logic [10:0]      col;
    logic [10:0]      row;
    t_block_avg       pending_blocks [$];
    int               fail_count;

    assign o_fail_count = fail_count;

    task automatic report(input string msg);
        $display("%0t ns: reduced level mismatch, %s", $time, msg);
        fail_count++;
    endtask

    // floor of the quarter of the sum of two pair sums
    function automatic logic [7:0] channel_avg(input logic [8:0] upper, input logic [8:0] lower);
        logic [9:0] total;
        total = upper + lower;
        return total[9:2];
    endfunction

    // advance the level by one source texel, returns 1 when a block completes
    function automatic bit reduce_texel(input t_texel tx, output t_block_avg res);
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] h;
        logic [CFG_W-1:0] last_col;
        logic [CFG_W-1:0] last_row;
        logic [CFG_W-1:0] next_col;
        logic [CFG_W-1:0] next_row;
        t_pair            pair;
        t_pair            above;
        int               slot;
        bit               produced;
        produced = 1'b0;
        res = '0;
        w = width_reg;
        if (w < DIM_MIN) w = DIM_MIN;
        if (w > CFG_W'(DEFAULT_MAX_WIDTH)) w = CFG_W'(DEFAULT_MAX_WIDTH);
        h = height_reg;
        if (h < DIM_MIN) h = DIM_MIN;
        if (h > HEIGHT_LIMIT) h = HEIGHT_LIMIT;
        slot = int'(col >> 1) % PAIR_SLOTS;
        if (!col[0]) begin
            held = tx;
        end else begin
            pair.red   = {1'b0, held.red}   + {1'b0, tx.red};
            pair.green = {1'b0, held.green} + {1'b0, tx.green};
            pair.blue  = {1'b0, held.blue}  + {1'b0, tx.blue};
            pair.alpha = {1'b0, held.alpha} + {1'b0, tx.alpha};
            if (!row[0]) begin
                pair_sums[slot] = pair;
            end else begin
                above = pair_sums[slot];
                last_col = {w[CFG_W-1:1], 1'b0} - 1'b1;
                last_row = {h[CFG_W-1:1], 1'b0} - 1'b1;
                res.red   = channel_avg(above.red, pair.red);
                res.green = channel_avg(above.green, pair.green);
                res.blue  = channel_avg(above.blue, pair.blue);
                res.alpha = channel_avg(above.alpha, pair.alpha);
                res.end_of_level = ({1'b0, col} == last_col) && ({1'b0, row} == last_row);
                produced = 1'b1;
            end
        end
        // raster position, wrapping at the end of the level
        next_col = {1'b0, col} + 1'b1;
        next_row = {1'b0, row};
        if (next_col >= w) begin
            next_col = '0;
            next_row = next_row + 1'b1;
            if (next_row >= h) next_row = '0;
        end
        col = next_col[10:0];
        row = next_row[10:0];
        return produced;
    endfunction

    // watch both channels and the configuration port
    always @(posedge i_clk) begin : watch
        t_texel     tx;
        t_block_avg want;
        t_block_avg got;
        logic [CFG_W-1:0] reg_val;
        if (!i_rst_n) begin
            width_reg  = DIM_RESET;
            height_reg = DIM_RESET;
            held       = '0;
            col        = '0;
            row        = '0;
            pending_blocks.delete();
        end else begin
            // register write restarts the level
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == REG_SOURCE_WIDTH) width_reg = i_pwdata[CFG_W-1:0];
                else height_reg = i_pwdata[CFG_W-1:0];
                held = '0;
                col  = '0;
                row  = '0;
            end
            // register read back
            if (i_psel && i_penable && !i_pwrite && i_pready) begin
                reg_val = (i_paddr[2] == REG_SOURCE_WIDTH) ? width_reg : height_reg;
                if (i_prdata[CFG_W-1:0] !== reg_val)
                    report($sformatf("register %0d read: expected %0d, got %0d",
                        i_paddr[2], reg_val, i_prdata[CFG_W-1:0]));
            end
            // accepted source texel request
            if (i_in_valid && !i_in_stall) begin
                tx.red   = i_in_red;
                tx.green = i_in_green;
                tx.blue  = i_in_blue;
                tx.alpha = i_in_alpha;
                if (reduce_texel(tx, want)) pending_blocks.push_back(want);
            end
            // accepted reduced texel
            if (i_out_valid && !i_out_stall) begin
                got = {i_out_red, i_out_green, i_out_blue, i_out_alpha, i_end_of_level};
                if (pending_blocks.size() == 0) begin
                    report($sformatf("reduced texel %h with none expected", got));
                end else begin
                    want = pending_blocks.pop_front();
                    if (got.red !== want.red)
                        report($sformatf("red: expected %0d, got %0d", want.red, got.red));
                    if (got.green !== want.green)
                        report($sformatf("green: expected %0d, got %0d",
                            want.green, got.green));
                    if (got.blue !== want.blue)
                        report($sformatf("blue: expected %0d, got %0d", want.blue, got.blue));
                    if (got.alpha !== want.alpha)
                        report($sformatf("alpha: expected %0d, got %0d",
                            want.alpha, got.alpha));
                    if (got.end_of_level !== want.end_of_level)
                        report($sformatf("end_of_level: expected %0b, got %0b",
                            want.end_of_level, got.end_of_level));
                end
            end
        end
        o_pending = pending_blocks.size();
    end

endmodule

// File: verif/tb_mipmap_box_downsample.sv
`timescale 1ns / 100ps

module tb_mipmap_box_downsample;
    import mbd_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PHASE_ITEMS  = 260;
    localparam int FULL_PREVIEW = 40;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [7:0]        i_in_red;
    logic [7:0]        i_in_green;
    logic [7:0]        i_in_blue;
    logic [7:0]        i_in_alpha;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [7:0]        o_out_red;
    logic [7:0]        o_out_green;
    logic [7:0]        o_out_blue;
    logic [7:0]        o_out_alpha;
    logic              o_end_of_level;

    int                fail_count;
    int                pending;
    int                in_idle_pct;
    int                out_stall_pct;
    int unsigned       cycle_count;

    mipmap_box_downsample dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_in_red       (i_in_red),
        .i_in_green     (i_in_green),
        .i_in_blue      (i_in_blue),
        .i_in_alpha     (i_in_alpha),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_red      (o_out_red),
        .o_out_green    (o_out_green),
        .o_out_blue     (o_out_blue),
        .o_out_alpha    (o_out_alpha),
        .o_end_of_level (o_end_of_level)
    );

    mip_level_checker chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .i_prdata       (prdata),
        .i_pready       (pready),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_in_red       (i_in_red),
        .i_in_green     (i_in_green),
        .i_in_blue      (i_in_blue),
        .i_in_alpha     (i_in_alpha),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_out_red      (o_out_red),
        .i_out_green    (o_out_green),
        .i_out_blue     (o_out_blue),
        .i_out_alpha    (o_out_alpha),
        .i_end_of_level (o_end_of_level),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // 4 ns clock
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("mipmap_box_downsample regression: fail");
            $finish;
        end
    end

    // receiver back-pressure
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    function automatic logic [7:0] texel_channel();
        if ($urandom_range(7) == 0) return $urandom_range(1) ? 8'hFF : 8'h00;
        return 8'($urandom_range(255));
    endfunction

    function automatic int eff_dim(input logic [CFG_W-1:0] d);
        if (d < DIM_MIN) return int'(DIM_MIN);
        if (d > CFG_W'(DEFAULT_MAX_WIDTH)) return DEFAULT_MAX_WIDTH;
        return int'(d);
    endfunction

    // one source texel request, held until accepted
    task automatic send_texel(input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b, input logic [7:0] a);
        @(negedge i_clk);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_red   <= r;
        i_in_green <= g;
        i_in_blue  <= b;
        i_in_alpha <= a;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic send_texels(input int count);
        for (int i = 0; i < count; i++)
            send_texel(texel_channel(), texel_channel(), texel_channel(), texel_channel());
    endtask

    // let all blocks drain before touching registers
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic apb_access(input logic idx, input logic wr, input logic [CFG_W-1:0] value);
        logic [DATA_W-1:0] word;
        word = $urandom();
        word[CFG_W-1:0] = value;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        settle();
        if ($urandom_range(1)) begin
            apb_access(REG_SOURCE_WIDTH, 1'b1, w);
            apb_access(REG_SOURCE_HEIGHT, 1'b1, h);
        end else begin
            apb_access(REG_SOURCE_HEIGHT, 1'b1, h);
            apb_access(REG_SOURCE_WIDTH, 1'b1, w);
        end
        if ($urandom_range(3) == 0) begin
            apb_access(REG_SOURCE_WIDTH, 1'b0, '0);
            apb_access(REG_SOURCE_HEIGHT, 1'b0, '0);
        end
    endtask

    initial begin : stimulus
        int               sent;
        int               n;
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] h;
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        i_in_valid    = 1'b0;
        i_in_red      = '0;
        i_in_green    = '0;
        i_in_blue     = '0;
        i_in_alpha    = '0;
        i_out_stall   = 1'b0;
        cycle_count   = 0;
        in_idle_pct   = 10;
        out_stall_pct = 50;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // sizes after reset read back
        apb_access(REG_SOURCE_WIDTH, 1'b0, '0);
        apb_access(REG_SOURCE_HEIGHT, 1'b0, '0);

        // smallest level: saturated channels, zeros, floor of remainders
        set_size(12'd2, 12'd2);
        repeat (4) send_texel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        repeat (4) send_texel(8'h00, 8'h00, 8'h00, 8'h00);
        send_texel(8'd255, 8'd0, 8'd1, 8'd128);
        send_texel(8'd255, 8'd0, 8'd2, 8'd128);
        send_texel(8'd255, 8'd0, 8'd3, 8'd128);
        send_texel(8'd254, 8'd3, 8'd4, 8'd127);

        // odd last column and row dropped
        set_size(12'd3, 12'd3);
        send_texels(9);

        // sizes below the minimum clamp to 2x2
        set_size(12'd0, 12'd1);
        send_texels(4);

        // sender idles lightly, receiver heavily; then swapped; then no gaps
        for (int phase = 0; phase < 3; phase++) begin
            in_idle_pct   = (phase == 0) ? 10 : (phase == 1) ? 50 : 0;
            out_stall_pct = (phase == 0) ? 50 : (phase == 1) ? 10 : 0;

            // opening texels of a level with one full-size dimension, cut short by the next write
            case (phase)
                0: set_size(12'd4095, 12'd1);
                1: set_size(12'd1, 12'd2048);
                default: set_size(12'd2, 12'd4095);
            endcase
            send_texels(FULL_PREVIEW);

            sent = 0;
            while (sent < PHASE_ITEMS) begin
                w = ($urandom_range(7) == 0) ? 12'($urandom_range(2, 80))
                                             : 12'($urandom_range(2, 20));
                h = 12'($urandom_range(2, 10));
                if ($urandom_range(15) == 0) w = 12'($urandom_range(1));
                if ($urandom_range(15) == 0) h = 12'($urandom_range(1));
                set_size(w, h);
                n = eff_dim(w) * eff_dim(h);
                // aborted level, restarted by the next register write
                if ($urandom_range(5) == 0) n = $urandom_range(1, n - 1);
                else if ($urandom_range(3) == 0) n = 2 * n;
                // keep the phase near its texel budget
                if (n > PHASE_ITEMS - sent) n = PHASE_ITEMS - sent;
                send_texels(n);
                sent += n;
            end
        end

        // drain
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("mipmap_box_downsample regression: pass");
        end else begin
            $display("mipmap_box_downsample regression: fail");
        end
        $finish;
    end

endmodule
